FILE: design/clipped_line_rasterizer_unit_assert.svh
// Assertion macros shared by the line rasteriser checkers.
// Depends on nothing; included by the checker file.
`ifndef CLIPPED_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define CLIPPED_LINE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/clr_pkg.sv
// Shared constants for the clipped line rasteriser.
// No dependencies; imported by the top level and its checker.
package clr_pkg;

    localparam int COORD_BITS = 12;
    localparam int SIDE_BITS  = 11;
    localparam int MAX_SIDE   = 1024;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int COLOR_BITS = 16;
    localparam int INDEX_BITS = 20;
    localparam int PROD_BITS  = 2 * SIDE_BITS;

    // Slave beat: four coordinates and the colour, padded to whole bytes
    localparam int S_FIELD_BITS = 4 * COORD_BITS + COLOR_BITS;
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    // Master beat: index and colour, padded to whole bytes
    localparam int M_FIELD_BITS = INDEX_BITS + COLOR_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [SIDE_BITS-1:0] WIDTH_RESET  = SIDE_BITS'(480);
    localparam logic [SIDE_BITS-1:0] HEIGHT_RESET = SIDE_BITS'(272);
    localparam logic [SIDE_BITS-1:0] SIDE_LIMIT   = SIDE_BITS'(MAX_SIDE);

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_TICK  = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1
    } t_cfg_reg;

endpackage

FILE: design/clipped_line_rasterizer_unit.sv
// Bresenham line stepper with screen clipping and row-major pixel addressing.
// A live tick beat gives its pixel beat on the master side in the next cycle.
// One beat per cycle unless the master side stalls; a start beat gives none.
// The pixel address multiply sits between the line state and the output
// register; the error update feeds the line state. Reset (synchronous, active
// low) idles the line and restores the screen size to 480 x 272.
module clipped_line_rasterizer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // x_start, y_start, x_finish, y_finish, pen_color, zero pad
    input  logic [clr_pkg::S_DATA_BITS-1:0] i_s_tdata,
    // kind
    input  logic                           i_s_tuser,
    // master side
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // pixel_index, pixel_color, zero pad
    output logic [clr_pkg::M_DATA_BITS-1:0] o_m_tdata,
    // write_enable
    output logic                           o_m_tuser,
    output logic                           o_m_tlast,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [clr_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [clr_pkg::SIDE_BITS-1:0]  i_cfg_data
);
    import clr_pkg::*;

    logic [SIDE_BITS-1:0]         r_width, r_height;
    logic                         r_active;
    logic signed [COORD_BITS-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [COORD_BITS-1:0]        r_span_x;
    logic signed [COORD_BITS:0]   r_neg_span_y;
    logic                         r_step_x_neg, r_step_y_neg;
    logic signed [ERR_BITS-1:0]   r_err;
    logic [COLOR_BITS-1:0]        r_color;

    logic                         r_m_valid;
    logic [INDEX_BITS-1:0]        r_m_index;
    logic [COLOR_BITS-1:0]        r_m_color;
    logic                         r_m_we, r_m_last;

    logic                         s_beat, is_start, is_tick;
    logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
    logic signed [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS:0]          abs_dx, abs_dy;
    logic [COORD_BITS-1:0]        n_span_x;
    logic signed [COORD_BITS:0]   n_neg_span_y;
    logic signed [ERR_BITS-1:0]   n_err_init;

    logic [SIDE_BITS-1:0]         w_lim, h_lim;
    logic                         in_view, at_end;
    logic [PROD_BITS-1:0]         prod, idx_sum;
    logic signed [ERR_BITS:0]     e2;
    logic                         adv_x, adv_y;
    logic signed [ERR_BITS-1:0]   n_err_step;
    logic signed [COORD_BITS-1:0] n_cur_x, n_cur_y;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_m_valid || i_m_tready;
    assign s_beat      = i_s_tvalid && o_s_tready;
    assign is_start    = s_beat && (t_kind'(i_s_tuser) == KIND_START);
    assign is_tick     = s_beat && (t_kind'(i_s_tuser) == KIND_TICK) && r_active;

    // Line set-up from the start beat
    assign x0 = i_s_tdata[0*COORD_BITS +: COORD_BITS];
    assign y0 = i_s_tdata[1*COORD_BITS +: COORD_BITS];
    assign x1 = i_s_tdata[2*COORD_BITS +: COORD_BITS];
    assign y1 = i_s_tdata[3*COORD_BITS +: COORD_BITS];

    always_comb begin
        dx           = (COORD_BITS+1)'(x1) - (COORD_BITS+1)'(x0);
        dy           = (COORD_BITS+1)'(y1) - (COORD_BITS+1)'(y0);
        abs_dx       = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
        abs_dy       = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
        n_span_x     = abs_dx[COORD_BITS-1:0];
        n_neg_span_y = -$signed(abs_dy);
        n_err_init   = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, n_span_x})
                     + ERR_BITS'(n_neg_span_y);
    end

    // Pixel record and one Bresenham step from the current point
    always_comb begin
        w_lim   = (r_width  > SIDE_LIMIT) ? SIDE_LIMIT : r_width;
        h_lim   = (r_height > SIDE_LIMIT) ? SIDE_LIMIT : r_height;
        in_view = !r_cur_x[COORD_BITS-1] && !r_cur_y[COORD_BITS-1]
                && ($unsigned(r_cur_x) < COORD_BITS'(w_lim))
                && ($unsigned(r_cur_y) < COORD_BITS'(h_lim));
        at_end  = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
        // row below the saturated height fits SIDE_BITS when on screen
        prod    = PROD_BITS'(r_cur_y[SIDE_BITS-1:0]) * PROD_BITS'(w_lim);
        idx_sum = prod + PROD_BITS'($unsigned(r_cur_x));

        e2      = {r_err, 1'b0};
        adv_x   = e2 >= (ERR_BITS+1)'(r_neg_span_y);
        adv_y   = e2 <= $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, r_span_x});
        n_err_step = r_err
                   + (adv_x ? ERR_BITS'(r_neg_span_y) : '0)
                   + (adv_y ? $signed({{(ERR_BITS-COORD_BITS){1'b0}}, r_span_x}) : '0);
        n_cur_x = adv_x ? (r_step_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1) : r_cur_x;
        n_cur_y = adv_y ? (r_step_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1) : r_cur_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_active  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                    CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end

            if (is_start) begin
                r_active     <= 1'b1;
                r_cur_x      <= x0;
                r_cur_y      <= y0;
                r_tgt_x      <= x1;
                r_tgt_y      <= y1;
                r_span_x     <= n_span_x;
                r_neg_span_y <= n_neg_span_y;
                r_step_x_neg <= !(x0 < x1);
                r_step_y_neg <= !(y0 < y1);
                r_err        <= n_err_init;
                r_color      <= i_s_tdata[4*COORD_BITS +: COLOR_BITS];
            end else if (is_tick) begin
                if (at_end) begin
                    r_active <= 1'b0;
                end else begin
                    r_cur_x <= n_cur_x;
                    r_cur_y <= n_cur_y;
                    r_err   <= n_err_step;
                end
            end

            // load a pixel beat on a live tick, drop the old one once taken
            if (is_tick) begin
                r_m_valid <= 1'b1;
                r_m_index <= in_view ? idx_sum[INDEX_BITS-1:0] : '0;
                r_m_color <= r_color;
                r_m_we    <= in_view;
                r_m_last  <= at_end;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(M_DATA_BITS-M_FIELD_BITS){1'b0}}, r_m_color, r_m_index};
    assign o_m_tuser  = r_m_we;
    assign o_m_tlast  = r_m_last;

endmodule

FILE: design/clr_checker.sv
// Port-level checker for the clipped line rasteriser, bound to the top level.
// Depends on clr_pkg and clipped_line_rasterizer_unit_assert.svh.
`include "clipped_line_rasterizer_unit_assert.svh"

module clr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [clr_pkg::M_DATA_BITS-1:0] o_m_tdata,
    input logic                            o_m_tuser,
    input logic                            o_m_tlast
);
    import clr_pkg::*;

    logic s_beat, start_beat, m_stall;

    assign s_beat     = i_s_tvalid && o_s_tready;
    assign start_beat = s_beat && (t_kind'(i_s_tuser) == KIND_START);
    assign m_stall    = o_m_tvalid && !i_m_tready;

    // hold a stalled pixel beat
    `CLR_ASSERT_NEXT(a_m_hold, i_clk, i_rst_n, m_stall, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled pixel beat changed")

    // clipped pixels carry a zero index
    `CLR_ASSERT_NOW(a_clip_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata[INDEX_BITS-1:0] == '0, "clipped pixel has non-zero index")

    // a start beat taken with the output empty makes no pixel beat
    `CLR_ASSERT_NEXT(a_start_silent, i_clk, i_rst_n, start_beat && !o_m_tvalid, !o_m_tvalid, "start beat produced a pixel")

    // an empty output register never back-pressures the slave side
    `CLR_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready, "slave stalled with empty output")

endmodule

bind clipped_line_rasterizer_unit clr_checker u_clr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
